@@ sv/assert_macros.svh @@
// Assertion helpers used by the top-level module to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ sv/sols_pkg.sv @@
// ----------------------------------------------------------------------------
// sols_pkg
// Shared constants and controller/datapath interface types of the
// self-organizing search table.
// ----------------------------------------------------------------------------
package sols_pkg;

  localparam int TABLE_SLOTS_DEFAULT = 32;

  localparam int WORD_W = 32;
  localparam int POS_W  = 5;
  localparam int MODE_W = 2;
  localparam int USE_W  = 6;
  localparam int CFG_W  = 6;

  localparam logic [MODE_W-1:0] MODE_PLAIN     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TRANSPOSE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TO_HEAD   = 2'd2;

  localparam logic CFG_SEARCH_MODE    = 1'b0;
  localparam logic CFG_ENTRIES_IN_USE = 1'b1;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic capture;
    logic do_write;
    logic scan_en;
    logic swap_rd;
    logic swap_wr;
    logic load_result;
  } sols_cmd_t;

  typedef struct packed {
    logic is_search;
    logic hit;
    logic swap_need;
    logic exhausted;
    logic res_busy;
  } sols_status_t;

endpackage

@@ sv/self_organizing_linear_search.sv @@
// ----------------------------------------------------------------------------
// self_organizing_linear_search
// Table of signed words with write and linear search, optionally reordered
// after a hit by transposition or by exchange with the head entry.
// ----------------------------------------------------------------------------
// Answer path: an accepted write passes the write and finish states; a search
// compares entries until the first hit or the end of the entries in use, and a
// hit that reorders the table also passes the swap read and swap write states.
// Throughput: one word at a time, one entry compared per cycle from the single
// read port; the next word is taken no earlier than its predecessor's answer.
// Reset: clears mode, entry count and control state; entry memory is not.
// ----------------------------------------------------------------------------
module self_organizing_linear_search #(
  parameter int TABLE_SLOTS = sols_pkg::TABLE_SLOTS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                opcode,
  input  logic [sols_pkg::POS_W-1:0]          entry_position,
  input  logic signed [sols_pkg::WORD_W-1:0]  item_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                answered_kind,
  output logic                                found,
  output logic [sols_pkg::POS_W-1:0]          found_position,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [sols_pkg::CFG_W-1:0]          cfg_data
);
  import sols_pkg::*;
  `include "assert_macros.svh"

  // The controller only sequences; every register that holds table data,
  // keys, indexes or results lives in the datapath.
  sols_cmd_t    cmd;
  sols_status_t status;

  sols_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  // The result register lets a new word be accepted while the previous
  // answer still waits on the output side.
  sols_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .in_opcode    (opcode),
    .in_position  (entry_position),
    .in_value     (item_value),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_kind     (answered_kind),
    .out_found    (found),
    .out_position (found_position)
  );

  // Only one word is in flight at a time.
  `ASSERT_NEXT(a_single_word, clk, rst, in_valid && in_ready, !in_ready)
  // A match can only be reported for a search.
  `ASSERT_IMPLY(a_found_is_search, clk, rst, out_valid && found, answered_kind == OP_SEARCH)
  // A write acknowledgement carries no position.
  `ASSERT_IMPLY(a_write_ack_clean, clk, rst, out_valid && (answered_kind == OP_WRITE), (!found) && (found_position == '0))
  // A compare hit means a read is pending, so the scan cannot also be done.
  `ASSERT_IMPLY(a_hit_not_done, clk, rst, status.hit, !status.exhausted)

endmodule

@@ sv/sols_ctrl.sv @@
// ----------------------------------------------------------------------------
// sols_ctrl
// Sequencer for write, scan, reorder and result hand-off.
// ----------------------------------------------------------------------------
module sols_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output sols_pkg::sols_cmd_t    cmd,
  input  sols_pkg::sols_status_t status
);
  import sols_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_SCAN,
    S_SWAP_RD,
    S_SWAP_WR,
    S_FINISH
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd             = '0;
    cmd.capture     = (state == S_IDLE) && in_valid;
    cmd.do_write    = (state == S_WRITE);
    cmd.scan_en     = (state == S_SCAN);
    cmd.swap_rd     = (state == S_SWAP_RD);
    cmd.swap_wr     = (state == S_SWAP_WR);
    cmd.load_result = (state == S_FINISH) && !status.res_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (status.is_search) begin
              state <= S_SCAN;
            end else begin
              state <= S_WRITE;
            end
          end
        end
        S_WRITE:   state <= S_FINISH;
        S_SCAN: begin
          if (status.hit) begin
            state <= status.swap_need ? S_SWAP_RD : S_FINISH;
          end else if (status.exhausted) begin
            state <= S_FINISH;
          end
        end
        S_SWAP_RD: state <= S_SWAP_WR;
        S_SWAP_WR: state <= S_FINISH;
        S_FINISH: begin
          if (!status.res_busy) begin
            state <= S_IDLE;
          end
        end
        default:   state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/sols_datapath.sv @@
// ----------------------------------------------------------------------------
// sols_datapath
// Entry memory, scan counter, match compare, swap addressing, configuration
// registers and the result register.
// ----------------------------------------------------------------------------
module sols_datapath #(
  parameter int TABLE_SLOTS = sols_pkg::TABLE_SLOTS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sols_pkg::sols_cmd_t                 cmd,
  output sols_pkg::sols_status_t              status,
  input  logic                                in_opcode,
  input  logic [sols_pkg::POS_W-1:0]          in_position,
  input  logic signed [sols_pkg::WORD_W-1:0]  in_value,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [sols_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                out_kind,
  output logic                                out_found,
  output logic [sols_pkg::POS_W-1:0]          out_position
);
  import sols_pkg::*;

  localparam int AW = $clog2(TABLE_SLOTS);
  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam int PW = (AW > POS_W) ? AW : POS_W;

  logic signed [WORD_W-1:0] mem [TABLE_SLOTS];
  logic signed [WORD_W-1:0] rdata;

  logic [MODE_W-1:0]        search_mode;
  logic [USE_W-1:0]         entries_in_use;

  logic                     op;
  logic [POS_W-1:0]         pos;
  logic signed [WORD_W-1:0] key;
  logic [CW-1:0]            idx;
  logic                     pend_valid;
  logic [AW-1:0]            pend_idx;
  logic                     found_r;
  logic [AW-1:0]            hit_idx;
  logic [AW-1:0]            partner;

  logic [CW-1:0]            limit;
  logic [PW-1:0]            pos_ext;
  logic [PW-1:0]            hit_ext;
  logic                     pos_ok;
  logic                     more;
  logic                     hit;
  logic [AW-1:0]            raddr;
  logic [AW-1:0]            waddr;
  logic signed [WORD_W-1:0] wdata;
  logic                     we;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_mode    <= MODE_PLAIN;
      entries_in_use <= '0;
    end else if (cfg_write) begin
      if (cfg_index == CFG_SEARCH_MODE) begin
        search_mode <= cfg_data[MODE_W-1:0];
      end else begin
        entries_in_use <= cfg_data[USE_W-1:0];
      end
    end
  end

  always_comb begin
    limit = CW'(entries_in_use);
    if (int'(entries_in_use) > TABLE_SLOTS) begin
      limit = CW'(TABLE_SLOTS);
    end
  end

  assign pos_ext = PW'(pos);
  assign hit_ext = PW'(hit_idx);
  assign pos_ok  = int'(pos) < TABLE_SLOTS;
  assign more    = idx < limit;
  assign hit     = pend_valid && (rdata == key);

  assign status.is_search = (in_opcode == OP_SEARCH);
  assign status.hit       = hit;
  assign status.swap_need = (pend_idx != '0) &&
                            ((search_mode == MODE_TRANSPOSE) ||
                             (search_mode == MODE_TO_HEAD));
  assign status.exhausted = !pend_valid && !more;
  assign status.res_busy  = out_valid && !out_ready;

  // The swap first writes the key into the partner slot while its old
  // contents are read out; the second step moves them into the hit slot.
  always_comb begin
    raddr = cmd.swap_rd ? partner : idx[AW-1:0];
    waddr = hit_idx;
    wdata = rdata;
    we    = cmd.swap_wr;
    if (cmd.do_write) begin
      waddr = pos_ext[AW-1:0];
      wdata = key;
      we    = pos_ok;
    end else if (cmd.swap_rd) begin
      waddr = partner;
      wdata = key;
      we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op  <= in_opcode;
      pos <= in_position;
      key <= in_value;
    end
    if (cmd.scan_en && hit) begin
      hit_idx <= pend_idx;
      partner <= (search_mode == MODE_TRANSPOSE) ? pend_idx - AW'(1) : '0;
    end else if (cmd.capture) begin
      hit_idx <= '0;
    end
    pend_idx <= idx[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      pend_valid <= 1'b0;
      found_r    <= 1'b0;
    end else if (cmd.capture) begin
      idx        <= '0;
      pend_valid <= 1'b0;
      found_r    <= 1'b0;
    end else if (cmd.scan_en) begin
      pend_valid <= more;
      if (more) begin
        idx <= idx + CW'(1);
      end
      if (hit) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_kind     <= op;
      out_found    <= found_r;
      out_position <= hit_ext[POS_W-1:0];
    end
  end

endmodule

@@ bench/search_answer_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// search_answer_checker
// Watches the word channels and the register port of the search table,
// keeps its own copy of the table and registers, and compares every answer
// with the one it predicts.
// ----------------------------------------------------------------------------
module search_answer_checker #(
  parameter int SLOTS = sols_pkg::TABLE_SLOTS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                opcode,
  input  logic [sols_pkg::POS_W-1:0]          entry_position,
  input  logic signed [sols_pkg::WORD_W-1:0]  item_value,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                answered_kind,
  input  logic                                found,
  input  logic [sols_pkg::POS_W-1:0]          found_position,
  input  logic                                cfg_write,
  input  logic                                cfg_index,
  input  logic [sols_pkg::CFG_W-1:0]          cfg_data,
  output int                                  fail_count,
  output int                                  outstanding
);
  import sols_pkg::*;

  typedef struct packed {
    logic             kind;
    logic             found;
    logic [POS_W-1:0] position;
  } answer_t;

  logic [WORD_W-1:0] slot_word [SLOTS];
  logic [MODE_W-1:0] mode_reg;
  logic [USE_W-1:0]  use_reg;
  answer_t           answer_q [$];
  answer_t           want;
  answer_t           got;

  // Applies one word to the shadow table and returns the answer it causes.
  function automatic answer_t predict_answer(input logic op, input logic [POS_W-1:0] pos,
                                             input logic [WORD_W-1:0] key);
    answer_t           a;
    int                limit;
    int                hit_at;
    bit                hit;
    logic [WORD_W-1:0] keep;
    a      = '0;
    a.kind = op;
    hit    = 1'b0;
    hit_at = 0;
    if (op == OP_WRITE) begin
      if (int'(pos) < SLOTS) slot_word[pos] = key;
    end else begin
      limit = (int'(use_reg) > SLOTS) ? SLOTS : int'(use_reg);
      for (int i = 0; i < limit; i++) begin
        if (!hit && slot_word[i] == key) begin
          hit    = 1'b1;
          hit_at = i;
        end
      end
      if (hit) begin
        if (mode_reg == MODE_TRANSPOSE && hit_at > 0) begin
          keep                = slot_word[hit_at];
          slot_word[hit_at]   = slot_word[hit_at-1];
          slot_word[hit_at-1] = keep;
        end else if (mode_reg == MODE_TO_HEAD) begin
          keep              = slot_word[hit_at];
          slot_word[hit_at] = slot_word[0];
          slot_word[0]      = keep;
        end
      end
    end
    a.found    = hit;
    a.position = hit_at[POS_W-1:0];
    return a;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) slot_word[i] = '0;
      mode_reg = MODE_PLAIN;
      use_reg  = '0;
      answer_q.delete();
      fail_count = 0;
      outstanding <= 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_SEARCH_MODE) mode_reg = cfg_data[MODE_W-1:0];
        else use_reg = cfg_data[USE_W-1:0];
      end
      if (in_valid && in_ready)
        answer_q.push_back(predict_answer(opcode, entry_position, item_value));
      if (out_valid && out_ready) begin
        got = '{answered_kind, found, found_position};
        if (answer_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: answer with none pending: kind=%0d found=%0d pos=%0d",
                     $realtime, got.kind, got.found, got.position);
          fail_count++;
        end else begin
          want = answer_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("%0t: mismatch kind %0d/%0d found %0d/%0d pos %0d/%0d (exp/act)",
                       $realtime, want.kind, got.kind, want.found, got.found,
                       want.position, got.position);
            fail_count++;
          end
        end
      end
      outstanding <= answer_q.size();
    end
  end

endmodule

@@ bench/tb_self_organizing_linear_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_self_organizing_linear_search
// Drives writes and searches into the self-organizing search table under
// every reorder mode and a range of entry counts, with random stalls on both
// channels; a separate checker predicts each answer and counts mismatches.
// ----------------------------------------------------------------------------
module tb_self_organizing_linear_search;
  import sols_pkg::*;

  localparam int SLOTS      = TABLE_SLOTS_DEFAULT;
  localparam int PHASES     = 12;
  localparam int PHASE_WORDS = 62;

  logic                      clk            = 1'b0;
  logic                      rst            = 1'b1;
  logic                      in_valid       = 1'b0;
  logic                      in_ready;
  logic                      opcode         = OP_WRITE;
  logic [POS_W-1:0]          entry_position = '0;
  logic signed [WORD_W-1:0]  item_value     = '0;
  logic                      out_valid;
  logic                      out_ready      = 1'b0;
  logic                      answered_kind;
  logic                      found;
  logic [POS_W-1:0]          found_position;
  logic                      cfg_write      = 1'b0;
  logic                      cfg_index      = CFG_SEARCH_MODE;
  logic [CFG_W-1:0]          cfg_data       = '0;

  int fail_count;
  int outstanding;

  // While calm is set neither side stalls, so back-to-back words get through.
  bit calm = 1'b0;

  // Positions that have been written since reset. A search never scans an
  // entry that is still unwritten, since its contents are undefined.
  bit [SLOTS-1:0] written = '0;
  int             use_count = 0;

  // Small pool of keys, so that searches hit often and duplicate entries
  // exercise the first-match rule.
  logic [WORD_W-1:0] value_pool [10];

  // Each phase pairs a reorder mode with an entry count. Mode 3 is the unused
  // code, which must behave as a plain search; counts above the table size
  // must saturate.
  int phase_mode [PHASES] = '{0, 1, 2, 3, 0, 1, 2, 3, 1, 2, 0, 1};
  int phase_use  [PHASES] = '{32, 5, 1, 16, 33, 0, 63, 2, 32, 20, 31, 8};

  always #5 clk = ~clk;

  self_organizing_linear_search #(
    .TABLE_SLOTS(SLOTS)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .entry_position (entry_position),
    .item_value     (item_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .answered_kind  (answered_kind),
    .found          (found),
    .found_position (found_position),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  search_answer_checker #(
    .SLOTS(SLOTS)
  ) u_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .entry_position (entry_position),
    .item_value     (item_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .answered_kind  (answered_kind),
    .found          (found),
    .found_position (found_position),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .outstanding    (outstanding)
  );

  // The receiver stalls with a chance of one in five, except during the calm stretch.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 20);
  end

  // Offers one word, after a random number of idle cycles, and returns on the
  // edge at which it is accepted. Valid is left high; the next call either
  // changes the payload at once or drops valid for its idle cycles.
  task automatic send_word(input logic op, input logic [POS_W-1:0] pos,
                           input logic [WORD_W-1:0] val);
    while (!calm && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    opcode         <= op;
    entry_position <= pos;
    item_value     <= val;
    if (op == OP_WRITE) written[pos] = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Registers change only while the block is idle: valid is dropped, every
  // answer must be back, and a few quiet cycles follow before the write.
  task automatic set_reg(input logic idx, input logic [CFG_W-1:0] data);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_ENTRIES_IN_USE) use_count = int'(data);
  endtask

  initial begin
    int               limit;
    int               fill;
    int               total;
    logic             op;
    logic [POS_W-1:0] pos;
    logic [WORD_W-1:0] val;

    total = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Right after reset no entry is in use, so any search
    // must miss.
    send_word(OP_SEARCH, POS_W'($urandom), 32'h0000_0000);
    send_word(OP_WRITE, 5'd0, 32'h8000_0000);
    send_word(OP_WRITE, 5'd1, 32'h7FFF_FFFF);
    send_word(OP_WRITE, 5'd2, 32'h0000_0000);
    send_word(OP_WRITE, 5'd31, 32'hFFFF_FFFF);
    send_word(OP_WRITE, 5'd3, 32'h8000_0000);
    set_reg(CFG_ENTRIES_IN_USE, 6'd4);
    // Plain mode: the duplicate at position 3 must lose to position 0, and
    // the entry at position 31 lies outside the entries in use.
    send_word(OP_SEARCH, POS_W'($urandom), 32'h7FFF_FFFF);
    send_word(OP_SEARCH, POS_W'($urandom), 32'h8000_0000);
    send_word(OP_SEARCH, POS_W'($urandom), 32'hFFFF_FFFF);
    // Transpose mode walks the zero entry toward the head; once there it
    // must stay put.
    set_reg(CFG_SEARCH_MODE, {4'b0000, MODE_TRANSPOSE});
    send_word(OP_SEARCH, POS_W'($urandom), 32'h0000_0000);
    send_word(OP_SEARCH, POS_W'($urandom), 32'h0000_0000);
    send_word(OP_SEARCH, POS_W'($urandom), 32'h0000_0000);
    // Move-to-head mode, including a hit that is already at the head.
    set_reg(CFG_SEARCH_MODE, {4'b1111, MODE_TO_HEAD});
    send_word(OP_SEARCH, POS_W'($urandom), 32'h8000_0000);
    send_word(OP_SEARCH, POS_W'($urandom), 32'h8000_0000);
    send_word(OP_SEARCH, POS_W'($urandom), 32'h7FFF_FFFF);
    // The unused mode code acts as a plain search.
    set_reg(CFG_SEARCH_MODE, 6'b101011);
    send_word(OP_SEARCH, POS_W'($urandom), 32'h0000_0000);
    send_word(OP_SEARCH, POS_W'($urandom), 32'h0000_3039);

    // Random part, one phase per register setting.
    for (int p = 0; p < PHASES; p++) begin
      set_reg(CFG_SEARCH_MODE, {4'($urandom_range(0, 15)), 2'(phase_mode[p])});
      set_reg(CFG_ENTRIES_IN_USE, 6'(phase_use[p]));
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7FFF_FFFF;
      value_pool[2] = 32'hFFFF_FFFF;
      value_pool[3] = 32'h0000_0000;
      for (int j = 4; j < 10; j++) value_pool[j] = $urandom;

      for (int k = 0; k < PHASE_WORDS; k++) begin
        calm  = (total >= 300 && total < 420);
        limit = (use_count > SLOTS) ? SLOTS : use_count;
        // Any entry in use that was never written gets filled first.
        fill = -1;
        for (int i = 0; i < limit; i++)
          if (!written[i] && fill < 0) fill = i;
        if (fill >= 0) begin
          op  = OP_WRITE;
          pos = POS_W'(fill);
        end else begin
          op = ($urandom_range(0, 99) < 55) ? OP_SEARCH : OP_WRITE;
          if (limit > 0 && $urandom_range(0, 99) < 60) pos = POS_W'($urandom_range(0, limit - 1));
          else pos = POS_W'($urandom_range(0, SLOTS - 1));
        end
        val = ($urandom_range(0, 99) < 75) ? value_pool[$urandom_range(0, 9)] : $urandom;
        send_word(op, pos, val);
        total++;
      end
    end
    calm = 1'b0;

    // Drain: drop valid, wait for every answer, then let a search's worth of
    // cycles pass so that any stray answer would still be seen.
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // A correct run needs well under half a millisecond, even with every
  // search scanning the whole table and both sides stalling.
  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ self_organizing_linear_search.f @@
+incdir+sv
sv/sols_pkg.sv
sv/sols_ctrl.sv
sv/sols_datapath.sv
sv/self_organizing_linear_search.sv
bench/search_answer_checker.sv
bench/tb_self_organizing_linear_search.sv
